@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the observer block.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMSO_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMSO_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dmso_pkg.sv @@
// Package of the delayed-measurement state observer: sizes, register codes,
// saturation helpers and the microcode program. No dependencies.
package dmso_pkg;

  // Depth of the measurement delay line and width of its pointer.
  localparam int DelayDepth = 16;
  localparam int DelayIdxW  = (DelayDepth > 1) ? $clog2(DelayDepth) : 1;

  // Configuration port geometry and register indexes.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgGainPos  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainVel  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainDist = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPlant    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStepTime = 3'd4;

  // Register values after reset.
  localparam logic signed [31:0] GainPosRst  = 32'sd2562326;
  localparam logic signed [31:0] GainVelRst  = 32'sd46814056;
  localparam logic signed [31:0] GainDistRst = 32'sd65536;
  localparam logic signed [31:0] PlantRst    = 32'sd385744896;
  localparam logic [23:0]        StepTimeRst = 24'd16777;

  // Rounding offsets for the Q16.16 products and the Q0.24 time step.
  localparam logic signed [63:0] Half16 = 64'sd32768;
  localparam logic signed [63:0] Half24 = 64'sd8388608;

  // Microcode address space.
  localparam int UpcW = 5;
  localparam logic [UpcW-1:0] UpcLoad = 5'd16;

  // Product selected for the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE, MUL_H0E, MUL_KS, MUL_H1E, MUL_H2E,
    MUL_DPOS_HI, MUL_DPOS_LO, MUL_DVEL_HI, MUL_DVEL_LO,
    MUL_DDIST_HI, MUL_DDIST_LO
  } mul_sel_e;

  // Accumulator update applied to the registered product.
  typedef enum logic [2:0] {
    ACC_HOLD, ACC_ZERO_R16, ACC_VEL_R16, ACC_ACC_R16, ACC_ZERO_HI, ACC_ACC_LO
  } acc_op_e;

  // Register write performed by a step.
  typedef enum logic [3:0] {
    WR_NONE, WR_ERR, WR_DPOS, WR_DVEL, WR_DDIST,
    WR_POS, WR_VEL, WR_DIST, WR_LOAD
  } wr_op_e;

  // Branch condition.
  typedef enum logic [0:0] {
    JMP_NONE, JMP_LOAD
  } jmp_e;

  // One control word of the program.
  typedef struct packed {
    jmp_e            jmp;
    logic [UpcW-1:0] target;
    logic            dl;
    mul_sel_e        mul;
    acc_op_e         acc;
    wr_op_e          wr;
    logic            fin;
  } uword_t;

  // Sign extension of a Q16.16 word to the accumulator width.
  function automatic logic signed [63:0] sext32(input logic signed [31:0] v);
    return $signed({{32{v[31]}}, v});
  endfunction

  // Saturation to the 32 bit state range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // Saturation to the 40 bit Q24.16 derivative range.
  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    if (v > 64'sd549755813887) begin
      return 40'sh7fffffffff;
    end else if (v < -64'sd549755813888) begin
      return 40'sh8000000000;
    end else begin
      return v[39:0];
    end
  endfunction

  // Program: each product goes into the product register and is then folded
  // into the accumulator register, from which a later step writes the result.
  function automatic uword_t ucode(input logic [UpcW-1:0] addr);
    uword_t w;
    w = '{jmp: JMP_NONE, target: '0, dl: 1'b0, mul: MUL_NONE,
          acc: ACC_HOLD, wr: WR_NONE, fin: 1'b0};
    unique case (addr)
      5'd0: begin
        w.jmp = JMP_LOAD;
        w.target = UpcLoad;
      end
      5'd1: w.dl = 1'b1;
      5'd2: w.wr = WR_ERR;
      5'd3: w.mul = MUL_H0E;
      5'd4: begin
        w.mul = MUL_KS;
        w.acc = ACC_VEL_R16;
      end
      5'd5: begin
        w.mul = MUL_H1E;
        w.acc = ACC_ZERO_R16;
        w.wr = WR_DPOS;
      end
      5'd6: begin
        w.mul = MUL_H2E;
        w.acc = ACC_ACC_R16;
      end
      5'd7: begin
        w.acc = ACC_ZERO_R16;
        w.wr = WR_DVEL;
      end
      5'd8: begin
        w.mul = MUL_DPOS_HI;
        w.wr = WR_DDIST;
      end
      5'd9: begin
        w.mul = MUL_DPOS_LO;
        w.acc = ACC_ZERO_HI;
      end
      5'd10: begin
        w.mul = MUL_DVEL_HI;
        w.acc = ACC_ACC_LO;
      end
      5'd11: begin
        w.mul = MUL_DVEL_LO;
        w.acc = ACC_ZERO_HI;
        w.wr = WR_POS;
      end
      5'd12: begin
        w.mul = MUL_DDIST_HI;
        w.acc = ACC_ACC_LO;
      end
      5'd13: begin
        w.mul = MUL_DDIST_LO;
        w.acc = ACC_ZERO_HI;
        w.wr = WR_VEL;
      end
      5'd14: w.acc = ACC_ACC_LO;
      5'd15: begin
        w.wr = WR_DIST;
        w.fin = 1'b1;
      end
      5'd16: begin
        w.wr = WR_LOAD;
        w.fin = 1'b1;
      end
      default: w.fin = 1'b1;
    endcase
    return w;
  endfunction

endpackage

@@ design/delayed_measurement_state_observer_core.sv @@
// Top level of the delayed-measurement state observer.
// Depends on dmso_pkg for sizes, helpers and the microcode program.
// Usage:
//   Requests enter on in_valid_i/in_ready_o. func_i = 0 is an observer step
//   using drive_i and measured_pos_i; func_i = 1 loads init_pos_i,
//   init_vel_i and init_dist_i and clears the measurement delay line.
//   Every request yields one result on out_valid_o/out_ready_i carrying the
//   position, velocity and disturbance estimates after the request.
//   Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i
//   while no request is in flight.
// Sequencing:
//   A step runs the whole program; a load branches from the first step
//   straight to its own final step. All ten products of a step share one
//   33x33 multiplier, which paces the program. One request is in flight at a
//   time and in_ready_o returns high as the result is posted, so a new
//   request is accepted only once the previous one has finished.
// Reset and stall:
//   Reset restores the register defaults, zeros the states and marks every
//   delay line entry empty (empty entries read as zero). A waiting result only
//   holds the final step of the next request until that result is taken.
module delayed_measurement_state_observer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dmso_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dmso_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic signed [31:0]                drive_i,
  input  logic signed [31:0]                measured_pos_i,
  input  logic signed [31:0]                init_pos_i,
  input  logic signed [31:0]                init_vel_i,
  input  logic signed [31:0]                init_dist_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [31:0]                est_pos_o,
  output logic signed [31:0]                est_vel_o,
  output logic signed [31:0]                est_dist_o
);

  // Configuration registers.
  logic signed [31:0] gain_pos_q, gain_vel_q, gain_dist_q, plant_q;
  logic [23:0]        step_time_q;

  // Sequencer control.
  logic                        busy_q;
  logic [dmso_pkg::UpcW-1:0]   upc_q;
  dmso_pkg::uword_t            uw;
  logic                        run;

  // Latched request.
  logic               func_q;
  logic signed [31:0] drive_q, meas_q, init_pos_q, init_vel_q, init_dist_q;

  // Observer state and delay line.
  logic signed [31:0]               pos_q, vel_q, dist_q;
  logic signed [31:0]               pos_d, vel_d, dist_d;
  logic signed [31:0]               delay_mem [dmso_pkg::DelayDepth];
  logic [dmso_pkg::DelayDepth-1:0]  dl_valid_q;
  logic [dmso_pkg::DelayIdxW-1:0]   dl_idx_q;
  logic signed [31:0]               yd_q;

  // Datapath registers.
  logic signed [31:0] e_q, s_q;
  logic signed [39:0] dpos_q, dvel_q, ddist_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic signed [63:0] prod64, prod_r16, acc_q, acc_d, acc_r24;
  logic signed [39:0] deriv_sel;

  // Output register.
  logic               out_valid_q;
  logic signed [31:0] out_pos_q, out_vel_q, out_dist_q;

  assign uw  = dmso_pkg::ucode(upc_q);
  // The final step waits while an earlier result is still unclaimed.
  assign run = busy_q && !(uw.fin && out_valid_q && !out_ready_i);
  assign in_ready_o = !busy_q;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_pos_q  <= dmso_pkg::GainPosRst;
      gain_vel_q  <= dmso_pkg::GainVelRst;
      gain_dist_q <= dmso_pkg::GainDistRst;
      plant_q     <= dmso_pkg::PlantRst;
      step_time_q <= dmso_pkg::StepTimeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dmso_pkg::CfgGainPos:  gain_pos_q  <= $signed(cfg_wdata_i);
        dmso_pkg::CfgGainVel:  gain_vel_q  <= $signed(cfg_wdata_i);
        dmso_pkg::CfgGainDist: gain_dist_q <= $signed(cfg_wdata_i);
        dmso_pkg::CfgPlant:    plant_q     <= $signed(cfg_wdata_i);
        dmso_pkg::CfgStepTime: step_time_q <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  // Step counter: start on a request, branch or advance, stop after the last step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= '0;
    end else if (!busy_q) begin
      if (in_valid_i) begin
        busy_q <= 1'b1;
        upc_q  <= '0;
      end
    end else if (run) begin
      if (uw.fin) begin
        busy_q <= 1'b0;
      end else if (uw.jmp == dmso_pkg::JMP_LOAD && func_q) begin
        upc_q <= uw.target;
      end else begin
        upc_q <= upc_q + 1'b1;
      end
    end
  end

  // Request fields are held for the whole program.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !busy_q) begin
      func_q      <= func_i;
      drive_q     <= drive_i;
      meas_q      <= measured_pos_i;
      init_pos_q  <= init_pos_i;
      init_vel_q  <= init_vel_i;
      init_dist_q <= init_dist_i;
    end
  end

  // Delay line storage: read the oldest sample and put the new one in its slot.
  always_ff @(posedge clk_i) begin
    if (run && uw.dl) begin
      yd_q <= dl_valid_q[dl_idx_q] ? delay_mem[dl_idx_q] : 32'sd0;
      delay_mem[dl_idx_q] <= meas_q;
    end
  end

  // Delay line occupancy and pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_valid_q <= '0;
      dl_idx_q   <= '0;
    end else if (run && uw.wr == dmso_pkg::WR_LOAD) begin
      dl_valid_q <= '0;
      dl_idx_q   <= '0;
    end else if (run && uw.dl) begin
      dl_valid_q[dl_idx_q] <= 1'b1;
      if (dl_idx_q == dmso_pkg::DelayIdxW'(dmso_pkg::DelayDepth - 1)) begin
        dl_idx_q <= '0;
      end else begin
        dl_idx_q <= dl_idx_q + 1'b1;
      end
    end
  end

  // Derivative operand for the time-step products.
  always_comb begin
    unique case (uw.mul)
      dmso_pkg::MUL_DPOS_HI, dmso_pkg::MUL_DPOS_LO: deriv_sel = dpos_q;
      dmso_pkg::MUL_DVEL_HI, dmso_pkg::MUL_DVEL_LO: deriv_sel = dvel_q;
      default:                                      deriv_sel = ddist_q;
    endcase
  end

  // Operand selection for the shared multiplier. A derivative is split into
  // a signed upper part and an unsigned lower 16 bits.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uw.mul)
      dmso_pkg::MUL_H0E: begin
        mul_a = 33'(gain_pos_q);
        mul_b = 33'(e_q);
      end
      dmso_pkg::MUL_KS: begin
        mul_a = 33'(plant_q);
        mul_b = 33'(s_q);
      end
      dmso_pkg::MUL_H1E: begin
        mul_a = 33'(gain_vel_q);
        mul_b = 33'(e_q);
      end
      dmso_pkg::MUL_H2E: begin
        mul_a = 33'(gain_dist_q);
        mul_b = 33'(e_q);
      end
      dmso_pkg::MUL_DPOS_HI, dmso_pkg::MUL_DVEL_HI, dmso_pkg::MUL_DDIST_HI: begin
        mul_a = $signed({{9{deriv_sel[39]}}, deriv_sel[39:16]});
        mul_b = $signed({9'd0, step_time_q});
      end
      dmso_pkg::MUL_DPOS_LO, dmso_pkg::MUL_DVEL_LO, dmso_pkg::MUL_DDIST_LO: begin
        mul_a = $signed({17'd0, deriv_sel[15:0]});
        mul_b = $signed({9'd0, step_time_q});
      end
      default: ;
    endcase
  end

  // Registered product.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Accumulator: rounded Q16.16 terms, or the two halves of a time-step product.
  assign prod64   = prod_q[63:0];
  assign prod_r16 = (prod64 + dmso_pkg::Half16) >>> 16;
  assign acc_r24  = (acc_q + dmso_pkg::Half24) >>> 24;

  always_comb begin
    unique case (uw.acc)
      dmso_pkg::ACC_ZERO_R16: acc_d = prod_r16;
      dmso_pkg::ACC_VEL_R16:  acc_d = dmso_pkg::sext32(vel_q) + prod_r16;
      dmso_pkg::ACC_ACC_R16:  acc_d = acc_q + prod_r16;
      dmso_pkg::ACC_ZERO_HI:  acc_d = $signed({prod_q[47:0], 16'd0});
      dmso_pkg::ACC_ACC_LO:   acc_d = acc_q + prod64;
      default:                acc_d = acc_q;
    endcase
  end

  // Error, drive sum and derivative registers.
  always_ff @(posedge clk_i) begin
    if (run) begin
      acc_q <= acc_d;
      unique case (uw.wr)
        dmso_pkg::WR_ERR: begin
          e_q <= dmso_pkg::sat32(dmso_pkg::sext32(yd_q) - dmso_pkg::sext32(pos_q));
          s_q <= dmso_pkg::sat32(dmso_pkg::sext32(dist_q) + dmso_pkg::sext32(drive_q));
        end
        dmso_pkg::WR_DPOS:  dpos_q  <= dmso_pkg::sat40(acc_q);
        dmso_pkg::WR_DVEL:  dvel_q  <= dmso_pkg::sat40(acc_q);
        dmso_pkg::WR_DDIST: ddist_q <= dmso_pkg::sat40(acc_q);
        default: ;
      endcase
    end
  end

  // Next state: Euler update with the rounded increment, or a load.
  always_comb begin
    pos_d  = pos_q;
    vel_d  = vel_q;
    dist_d = dist_q;
    if (run) begin
      unique case (uw.wr)
        dmso_pkg::WR_POS:  pos_d  = dmso_pkg::sat32(dmso_pkg::sext32(pos_q) + acc_r24);
        dmso_pkg::WR_VEL:  vel_d  = dmso_pkg::sat32(dmso_pkg::sext32(vel_q) + acc_r24);
        dmso_pkg::WR_DIST: dist_d = dmso_pkg::sat32(dmso_pkg::sext32(dist_q) + acc_r24);
        dmso_pkg::WR_LOAD: begin
          pos_d  = init_pos_q;
          vel_d  = init_vel_q;
          dist_d = init_dist_q;
        end
        default: ;
      endcase
    end
  end

  // Observer states.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      vel_q  <= '0;
      dist_q <= '0;
    end else begin
      pos_q  <= pos_d;
      vel_q  <= vel_d;
      dist_q <= dist_d;
    end
  end

  // Result register, filled by the last step with the updated states.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (run && uw.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run && uw.fin) begin
      out_pos_q  <= pos_d;
      out_vel_q  <= vel_d;
      out_dist_q <= dist_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign est_pos_o   = out_pos_q;
  assign est_vel_o   = out_vel_q;
  assign est_dist_o  = out_dist_q;

endmodule

@@ design/dmso_checker.sv @@
// Port-level checks for the delayed-measurement state observer core.
// Depends on assert_macros.svh; bound to the top level at the end of this file.
`include "assert_macros.svh"

module dmso_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] est_pos_o,
  input logic [31:0] est_vel_o,
  input logic [31:0] est_dist_o
);

  // A stalled result stays posted.
  `DMSO_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  // A stalled result keeps its payload.
  `DMSO_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(est_pos_o) && $stable(est_vel_o) && $stable(est_dist_o), "result changed while stalled")

  // Only one request is in flight: accepting one closes the input.
  `DMSO_ASSERT_NXT(a_one_inflight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "second request taken while busy")

  // A new result appears exactly when the sequencer frees the input.
  `DMSO_ASSERT_IMP(a_result_frees, clk_i, rst_ni, $rose(out_valid_o), $rose(in_ready_o), "result posted without finishing a request")

endmodule

bind delayed_measurement_state_observer_core dmso_checker u_dmso_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .est_pos_o   (est_pos_o),
  .est_vel_o   (est_vel_o),
  .est_dist_o  (est_dist_o)
);

@@ tb/sv/delayed_measurement_state_observer_core_test.sv @@
// Self-checking testbench for the delayed-measurement state observer core.
// Predicts each estimate in fixed point, or takes a typed one, and compares it with the block's result.
// Depends on dmso_pkg and the delayed_measurement_state_observer_core RTL.
`timescale 1ns / 100ps

module delayed_measurement_state_observer_core_test;

  // Request codes of the func field.
  typedef enum logic {
    FUNC_STEP = 1'b0,
    FUNC_LOAD = 1'b1
  } obs_func_e;

  typedef struct packed {
    obs_func_e          func;
    logic signed [31:0] drive;
    logic signed [31:0] measured_pos;
    logic signed [31:0] init_pos;
    logic signed [31:0] init_vel;
    logic signed [31:0] init_dist;
  } obs_request_t;

  typedef struct packed {
    logic signed [31:0] est_pos;
    logic signed [31:0] est_vel;
    logic signed [31:0] est_dist;
  } obs_estimate_t;

  typedef struct packed {
    obs_request_t  req;
    logic          typed_in;
    obs_estimate_t est;
  } directed_row_t;

  localparam logic signed [31:0] QMax    = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin    = 32'sh8000_0000;
  localparam logic signed [31:0] QZero   = 32'sh0000_0000;
  localparam logic signed [31:0] QOne    = 32'sh0001_0000;
  localparam logic signed [31:0] QNegOne = 32'shffff_0000;
  localparam logic signed [31:0] QHalf   = 32'sh0000_8000;

  localparam longint StateMax = 64'sd2147483647;
  localparam longint StateMin = -64'sd2147483648;
  localparam longint DerivMax = 64'sd549755813887;
  localparam longint DerivMin = -64'sd549755813888;

  localparam int NumDirected   = 21;
  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 50;
  localparam int SettleCycles  = 24;
  localparam int CycleLimit    = 200000;
  localparam int NumUnusedIdx  = (1 << dmso_pkg::CfgIdxW) - 1 - dmso_pkg::CfgStepTime;

  logic                               clk_i          = 1'b0;
  logic                               rst_ni         = 1'b0;
  logic                               cfg_we_i       = 1'b0;
  logic [dmso_pkg::CfgIdxW-1:0]       cfg_idx_i      = '0;
  logic [dmso_pkg::CfgDataW-1:0]      cfg_wdata_i    = '0;
  logic                               in_valid_i     = 1'b0;
  logic                               in_ready_o;
  logic                               func_i         = FUNC_STEP;
  logic signed [31:0]                 drive_i        = '0;
  logic signed [31:0]                 measured_pos_i = '0;
  logic signed [31:0]                 init_pos_i     = '0;
  logic signed [31:0]                 init_vel_i     = '0;
  logic signed [31:0]                 init_dist_i    = '0;
  logic                               out_valid_o;
  logic                               out_ready_i    = 1'b0;
  logic signed [31:0]                 est_pos_o;
  logic signed [31:0]                 est_vel_o;
  logic signed [31:0]                 est_dist_o;

  // Observer copy: states, measurement history and registers.
  logic signed [31:0] obs_pos  = '0;
  logic signed [31:0] obs_vel  = '0;
  logic signed [31:0] obs_dist = '0;
  logic signed [31:0] meas_history [dmso_pkg::DelayDepth] = '{default: '0};
  int                 history_ptr    = 0;
  logic signed [31:0] corr_pos_gain  = dmso_pkg::GainPosRst;
  logic signed [31:0] corr_vel_gain  = dmso_pkg::GainVelRst;
  logic signed [31:0] corr_dist_gain = dmso_pkg::GainDistRst;
  logic signed [31:0] accel_gain     = dmso_pkg::PlantRst;
  logic [23:0]        dt_q24         = dmso_pkg::StepTimeRst;

  obs_estimate_t expected_estimates [$];
  int            mismatch_count  = 0;
  int            cycle_count     = 0;
  int            sender_idle_pct = 0;
  int            stall_pct       = 0;

  // Directed requests; typed rows carry estimates that are obvious by inspection.
  directed_row_t directed_rows [NumDirected] = '{
    '{'{FUNC_STEP, QZero, QZero, QMax, QMax, QMax}, 1'b1, '{QZero, QZero, QZero}},
    '{'{FUNC_STEP, QMax, QMin, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_STEP, QMin, QMax, QMin, QMin, QMin}, 1'b0, '0},
    '{'{FUNC_STEP, QNegOne, QOne, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_LOAD, QMax, QMax, QMax, QMin, QZero}, 1'b1, '{QMax, QMin, QZero}},
    '{'{FUNC_STEP, QZero, QZero, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_STEP, QMax, QMax, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_LOAD, QMin, QMin, QMin, QMax, QMin}, 1'b1, '{QMin, QMax, QMin}},
    '{'{FUNC_STEP, QMin, QMin, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_LOAD, QNegOne, QNegOne, QZero, QZero, QZero}, 1'b1, '{QZero, QZero, QZero}},
    '{'{FUNC_STEP, QZero, QOne, QZero, QZero, QZero}, 1'b1, '{QZero, QZero, QZero}},
    '{'{FUNC_STEP, QZero, QOne, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_STEP, QZero, QOne, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_STEP, QZero, QOne, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_STEP, QZero, QOne, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_STEP, QOne, QNegOne, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_STEP, QZero, QHalf, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_STEP, QZero, QHalf, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_STEP, QZero, QHalf, QZero, QZero, QZero}, 1'b0, '0},
    '{'{FUNC_LOAD, QZero, QZero, QOne, QNegOne, QHalf}, 1'b1, '{QOne, QNegOne, QHalf}},
    '{'{FUNC_STEP, QNegOne, QZero, QZero, QZero, QZero}, 1'b0, '0}
  };

  delayed_measurement_state_observer_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .drive_i        (drive_i),
    .measured_pos_i (measured_pos_i),
    .init_pos_i     (init_pos_i),
    .init_vel_i     (init_vel_i),
    .init_dist_i    (init_dist_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .est_pos_o      (est_pos_o),
    .est_vel_o      (est_vel_o),
    .est_dist_o     (est_dist_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Round half up to the nearest step of 2^n; the arithmetic shift floors.
  function automatic longint round_shr(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // Applies one request to the observer copy and returns the estimates after it.
  function automatic obs_estimate_t predict_estimate(input obs_request_t r);
    longint pos, vel, dst, delayed, err, drive_sum, d_pos, d_vel, d_dst, dt;
    obs_estimate_t est;
    if (r.func == FUNC_LOAD) begin
      obs_pos      = r.init_pos;
      obs_vel      = r.init_vel;
      obs_dist     = r.init_dist;
      meas_history = '{default: '0};
      history_ptr  = 0;
    end else begin
      pos = obs_pos;
      vel = obs_vel;
      dst = obs_dist;
      dt  = longint'(dt_q24);
      // The correction uses the sample taken a full history length ago.
      delayed = meas_history[history_ptr];
      meas_history[history_ptr] = r.measured_pos;
      history_ptr = (history_ptr == dmso_pkg::DelayDepth - 1) ? 0 : history_ptr + 1;

      err       = clip(delayed - pos, StateMin, StateMax);
      drive_sum = clip(dst + longint'(r.drive), StateMin, StateMax);
      d_pos = clip(vel + round_shr(longint'(corr_pos_gain) * err, 16), DerivMin, DerivMax);
      d_vel = clip(round_shr(longint'(accel_gain) * drive_sum, 16)
                   + round_shr(longint'(corr_vel_gain) * err, 16), DerivMin, DerivMax);
      d_dst = clip(round_shr(longint'(corr_dist_gain) * err, 16), DerivMin, DerivMax);

      // Forward Euler with a Q0.24 time step.
      obs_pos  = 32'(clip(pos + round_shr(d_pos * dt, 24), StateMin, StateMax));
      obs_vel  = 32'(clip(vel + round_shr(d_vel * dt, 24), StateMin, StateMax));
      obs_dist = 32'(clip(dst + round_shr(d_dst * dt, 24), StateMin, StateMax));
    end
    est.est_pos  = obs_pos;
    est.est_vel  = obs_vel;
    est.est_dist = obs_dist;
    return est;
  endfunction

  // Small values around zero and full-range values equally often, and some extremes.
  function automatic logic signed [31:0] random_q16();
    case ($urandom_range(9))
      0: return QMax;
      1: return QMin;
      2, 3, 4, 5: return $urandom_range(0, 262143) - 131072;
      default: return $urandom;
    endcase
  endfunction

  function automatic obs_request_t random_request();
    obs_request_t r;
    r.func         = ($urandom_range(9) == 0) ? FUNC_LOAD : FUNC_STEP;
    r.drive        = random_q16();
    r.measured_pos = random_q16();
    r.init_pos     = random_q16();
    r.init_vel     = random_q16();
    r.init_dist    = random_q16();
    return r;
  endfunction

  // Register value for a given phase: extremes, zero step time, defaults or random.
  function automatic logic [dmso_pkg::CfgDataW-1:0] register_value(
      input int phase, input logic [dmso_pkg::CfgIdxW-1:0] idx);
    case (phase)
      1: return (idx == dmso_pkg::CfgStepTime) ? 32'hffff_ffff : QMax;
      2: return (idx == dmso_pkg::CfgStepTime) ? 32'h0 : QMin;
      4: begin
        case (idx)
          dmso_pkg::CfgGainPos:  return dmso_pkg::GainPosRst;
          dmso_pkg::CfgGainVel:  return dmso_pkg::GainVelRst;
          dmso_pkg::CfgGainDist: return dmso_pkg::GainDistRst;
          dmso_pkg::CfgPlant:    return dmso_pkg::PlantRst;
          default:               return 32'(dmso_pkg::StepTimeRst);
        endcase
      end
      5: begin
        if (idx == dmso_pkg::CfgStepTime) begin
          return $urandom_range(0, 65535);
        end
        return $urandom_range(0, 2097151) - 1048576;
      end
      default: return $urandom;
    endcase
  endfunction

  // One register write; unknown indexes leave the registers untouched.
  task automatic write_register(input logic [dmso_pkg::CfgIdxW-1:0] idx,
                                input logic [dmso_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      dmso_pkg::CfgGainPos:  corr_pos_gain  = data;
      dmso_pkg::CfgGainVel:  corr_vel_gain  = data;
      dmso_pkg::CfgGainDist: corr_dist_gain = data;
      dmso_pkg::CfgPlant:    accel_gain     = data;
      dmso_pkg::CfgStepTime: dt_q24         = data[23:0];
      default: ;
    endcase
  endtask

  // Presents one request, waits for the handshake and records the expected estimates.
  // Valid is left high so that a following request can go out without a gap.
  task automatic send_request(input obs_request_t r, input logic typed_in,
                              input obs_estimate_t typed_est);
    obs_estimate_t est;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= r.func;
    drive_i        <= r.drive;
    measured_pos_i <= r.measured_pos;
    init_pos_i     <= r.init_pos;
    init_vel_i     <= r.init_vel;
    init_dist_i    <= r.init_dist;
    do @(posedge clk_i); while (!in_ready_o);
    est = predict_estimate(r);
    expected_estimates.push_back(typed_in ? typed_est : est);
  endtask

  // Lets every outstanding result arrive, then gives the sequencer time to go idle.
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (expected_estimates.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d (%h) actual %0d (%h)", $time, name, want, want, got, got);
      mismatch_count++;
    end
  endtask

  // Result side: compare each accepted result, then decide the next ready value.
  always @(posedge clk_i) begin
    obs_estimate_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_estimates.size() == 0) begin
        $display("%0t: result without a pending request: pos %0d vel %0d dist %0d",
                 $time, est_pos_o, est_vel_o, est_dist_o);
        mismatch_count++;
      end else begin
        want = expected_estimates.pop_front();
        check_field("est_pos", want.est_pos, est_pos_o);
        check_field("est_vel", want.est_vel, est_vel_o);
        check_field("est_dist", want.est_dist, est_dist_o);
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: run did not complete within %0d cycles", $time, CycleLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus: reset, directed requests, then random phases with new settings.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_request(directed_rows[i].req, directed_rows[i].typed_in, directed_rows[i].est);
    end
    drain_requests();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct       = 0;
        end
        1: begin
          sender_idle_pct = 51;
          stall_pct       = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct       = 51;
        end
        default: begin
          sender_idle_pct = 36;
          stall_pct       = 36;
        end
      endcase
      // The first phase keeps the reset settings.
      if (phase != 0) begin
        for (int idx = dmso_pkg::CfgGainPos; idx <= dmso_pkg::CfgStepTime; idx++) begin
          write_register(dmso_pkg::CfgIdxW'(idx),
                         register_value(phase, dmso_pkg::CfgIdxW'(idx)));
        end
        write_register(dmso_pkg::CfgIdxW'(dmso_pkg::CfgStepTime + 1
                                          + $urandom_range(0, NumUnusedIdx - 1)),
                       $urandom);
        cfg_we_i <= 1'b0;
        @(posedge clk_i);
      end
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_request(random_request(), 1'b0, '0);
      end
      drain_requests();
    end

    if (mismatch_count == 0 && expected_estimates.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/dmso_pkg.sv
design/delayed_measurement_state_observer_core.sv
design/dmso_checker.sv
tb/sv/delayed_measurement_state_observer_core_test.sv
